[src/ilu_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the iterative lens undistortion pipeline
// no dependencies
package ilu_pkg;

    localparam int NORM_W = 23;
    localparam logic [NORM_W-1:0] NORM_LIMIT = NORM_W'(2097152);
    localparam int ONE_Q16 = 65536;

    localparam logic [2:0] REG_FOCAL_X       = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y       = 3'd1;
    localparam logic [2:0] REG_CENTER_X      = 3'd2;
    localparam logic [2:0] REG_CENTER_Y      = 3'd3;
    localparam logic [2:0] REG_RADIAL_K1     = 3'd4;
    localparam logic [2:0] REG_RADIAL_K2     = 3'd5;
    localparam logic [2:0] REG_TANGENTIAL_P1 = 3'd6;
    localparam logic [2:0] REG_TANGENTIAL_P2 = 3'd7;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SAT   = 2'd1,
        STATUS_DENOM = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] corrected_x;
        logic [15:0] corrected_y;
        status_t     status;
    } out_beat_t;

endpackage

[src/ilu_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider: an overflow check, then one quotient bit per stage, clamped signed result
// depends on ilu_pkg
module ilu_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               vld_in,
    input  logic [NW-1:0]                      num_mag,
    input  logic                               num_neg,
    input  logic [DW-1:0]                      den,
    input  logic [SW-1:0]                      side_in,
    output logic                               vld_out,
    output logic signed [ilu_pkg::NORM_W-1:0]  quo,
    output logic [SW-1:0]                      side_out
);
    import ilu_pkg::*;

    localparam int QW = NORM_W;
    localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;
    localparam int NS = QW + 2;

    logic [WW-1:0] rem_reg  [NS];
    logic [WW-1:0] rem_next [NS];
    logic [QW-1:0] q_reg    [NS];
    logic [QW-1:0] q_next   [NS];
    logic          ovf_reg  [NS];
    logic          ovf_next [NS];
    logic          neg_reg  [NS];
    logic          neg_next [NS];
    logic [DW-1:0] den_reg  [NS];
    logic [DW-1:0] den_next [NS];
    logic [SW-1:0] side_reg [NS];
    logic [SW-1:0] side_next[NS];
    logic          vld_reg  [NS];
    logic          vld_next [NS];

    logic [QW-1:0]               mag;
    logic signed [NORM_W-1:0]    quo_reg;
    logic                        vld_out_reg;
    logic [SW-1:0]               side_out_reg;

    always_comb
    begin
        rem_next[0]  = WW'(num_mag);
        q_next[0]    = '0;
        ovf_next[0]  = 1'b0;
        neg_next[0]  = num_neg;
        den_next[0]  = den;
        side_next[0] = side_in;
        vld_next[0]  = vld_in;
        for (int k = 1; k < NS; k++)
        begin
            rem_next[k]  = rem_reg[k-1];
            q_next[k]    = q_reg[k-1];
            ovf_next[k]  = ovf_reg[k-1];
            neg_next[k]  = neg_reg[k-1];
            den_next[k]  = den_reg[k-1];
            side_next[k] = side_reg[k-1];
            vld_next[k]  = vld_reg[k-1];
            if (k == 1)
            begin
                ovf_next[k] = rem_reg[0] >= (WW'(den_reg[0]) << QW);
            end
            else if (rem_reg[k-1] >= (WW'(den_reg[k-1]) << (NS - 1 - k)))
            begin
                rem_next[k] = rem_reg[k-1] - (WW'(den_reg[k-1]) << (NS - 1 - k));
                q_next[k][NS-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
            vld_out_reg <= vld_reg[NS-1];
        end
    end

    assign mag = (ovf_reg[NS-1] || (q_reg[NS-1] > NORM_LIMIT)) ? NORM_LIMIT : q_reg[NS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                ovf_reg[k]  <= ovf_next[k];
                neg_reg[k]  <= neg_next[k];
                den_reg[k]  <= den_next[k];
                side_reg[k] <= side_next[k];
            end
            quo_reg      <= neg_reg[NS-1] ? $signed(-mag) : $signed(mag);
            side_out_reg <= side_reg[NS-1];
        end
    end

    assign vld_out  = vld_out_reg;
    assign quo      = quo_reg;
    assign side_out = side_out_reg;

endmodule

[src/iterative_lens_undistort_top.sv]
`timescale 1ns / 1ps
// throughput: one beat per cycle while the output skid stage is empty; each iteration is
// five arithmetic stages plus a 26-stage pipelined divider per coordinate, and the
// normalizing division is one more
// reset: clears all valid bits and loads the default camera registers
// depends on ilu_pkg and ilu_div
module iterative_lens_undistort_top #(
    parameter int ITERATIONS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ilu_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ilu_pkg::out_beat_t out_data,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import ilu_pkg::*;

    typedef struct packed {
        logic [15:0]              px;
        logic [15:0]              py;
        logic signed [NORM_W-1:0] x0;
        logic signed [NORM_W-1:0] y0;
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic                     fault;
    } carry_t;

    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [15:0] k1_reg, k2_reg, p1_reg, p2_reg;
    logic [15:0] fx_eff, fy_eff;
    logic signed [15:0] k1s, k2s, p1s, p2s;

    logic en;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 16'd8000;
            focal_y_reg  <= 16'd8000;
            center_x_reg <= 16'd5120;
            center_y_reg <= 16'd3840;
            k1_reg       <= '0;
            k2_reg       <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FOCAL_X:       focal_x_reg  <= cfg_data;
                REG_FOCAL_Y:       focal_y_reg  <= cfg_data;
                REG_CENTER_X:      center_x_reg <= cfg_data;
                REG_CENTER_Y:      center_y_reg <= cfg_data;
                REG_RADIAL_K1:     k1_reg       <= cfg_data;
                REG_RADIAL_K2:     k2_reg       <= cfg_data;
                REG_TANGENTIAL_P1: p1_reg       <= cfg_data;
                REG_TANGENTIAL_P2: p2_reg       <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign fx_eff = (focal_x_reg == '0) ? 16'd1 : focal_x_reg;
    assign fy_eff = (focal_y_reg == '0) ? 16'd1 : focal_y_reg;
    assign k1s = $signed(k1_reg);
    assign k2s = $signed(k2_reg);
    assign p1s = $signed(p1_reg);
    assign p2s = $signed(p2_reg);

    // input stage
    logic        s0_vld_reg;
    logic [15:0] s0_px_reg, s0_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            s0_px_reg <= in_data.pixel_x;
            s0_py_reg <= in_data.pixel_y;
        end
    end

    assign in_ready = en;

    // normalize: (pixel - center) * 2^16 / focal
    logic signed [16:0] dx0, dy0;
    logic [16:0]        dx0_mag, dy0_mag;
    logic               n_xv, n_yv;
    logic signed [NORM_W-1:0] n_x, n_y;
    logic [15:0]        n_px, n_py;

    assign dx0 = $signed({1'b0, s0_px_reg}) - $signed({1'b0, center_x_reg});
    assign dy0 = $signed({1'b0, s0_py_reg}) - $signed({1'b0, center_y_reg});
    assign dx0_mag = dx0[16] ? 17'(-dx0) : 17'(dx0);
    assign dy0_mag = dy0[16] ? 17'(-dy0) : 17'(dy0);

    ilu_div #(.NW(32), .DW(16), .SW(16)) u_norm_x (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(s0_vld_reg),
        .num_mag({dx0_mag[15:0], 16'b0}), .num_neg(dx0[16]), .den(fx_eff),
        .side_in(s0_px_reg), .vld_out(n_xv), .quo(n_x), .side_out(n_px)
    );

    ilu_div #(.NW(32), .DW(16), .SW(16)) u_norm_y (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(s0_vld_reg),
        .num_mag({dy0_mag[15:0], 16'b0}), .num_neg(dy0[16]), .den(fy_eff),
        .side_in(s0_py_reg), .vld_out(n_yv), .quo(n_y), .side_out(n_py)
    );

    carry_t it_c [ITERATIONS+1];
    logic   it_v [ITERATIONS+1];

    always_comb
    begin
        it_c[0].px    = n_px;
        it_c[0].py    = n_py;
        it_c[0].x0    = n_x;
        it_c[0].y0    = n_y;
        it_c[0].x     = n_x;
        it_c[0].y     = n_y;
        it_c[0].fault = 1'b0;
        it_v[0]       = n_xv & n_yv;
    end

    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_iter
        carry_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
        logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
        logic signed [45:0] xx_p_reg, yy_p_reg, xy_p_reg;
        logic signed [28:0] r2_reg, xx_reg, yy_reg, xy_reg;
        logic signed [28:0] r2_3_reg, r2_4_reg;
        logic signed [44:0] kp_reg, sxy1_reg, sxy2_reg;
        logic signed [45:0] tx_reg, ty_reg;
        logic signed [33:0] poly_reg;
        logic signed [34:0] ddx_reg, ddy_reg;
        logic signed [62:0] pm_reg;
        logic signed [35:0] nx_reg, ny_reg;

        logic [46:0]        sum_r2;
        logic signed [29:0] ax, ay;
        logic signed [47:0] denom;
        logic               fault_next;
        logic [35:0]        nx_mag, ny_mag;
        logic               dxv, dyv;
        logic signed [NORM_W-1:0] qx, qy;
        logic [39:0]        sx_out;
        logic [38:0]        sy_out;

        assign sum_r2 = 47'(xx_p_reg) + 47'(yy_p_reg);
        assign ax = 30'(r2_reg) + (30'(xx_reg) <<< 1);
        assign ay = 30'(r2_reg) + (30'(yy_reg) <<< 1);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
                v3_reg <= 1'b0;
                v4_reg <= 1'b0;
                v5_reg <= 1'b0;
            end
            else if (en)
            begin
                v1_reg <= it_v[g];
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // squares and cross product
                c1_reg   <= it_c[g];
                xx_p_reg <= $signed(it_c[g].x) * $signed(it_c[g].x);
                yy_p_reg <= $signed(it_c[g].y) * $signed(it_c[g].y);
                xy_p_reg <= $signed(it_c[g].x) * $signed(it_c[g].y);
                // r2 and scaled products
                c2_reg <= c1_reg;
                r2_reg <= $signed(sum_r2[44:16]);
                xx_reg <= $signed(xx_p_reg[44:16]);
                yy_reg <= $signed(yy_p_reg[44:16]);
                xy_reg <= $signed(xy_p_reg[44:16]);
                // coefficient products
                c3_reg   <= c2_reg;
                r2_3_reg <= r2_reg;
                kp_reg   <= k2s * r2_reg;
                sxy1_reg <= p1s * xy_reg;
                sxy2_reg <= p2s * xy_reg;
                tx_reg   <= p2s * ax;
                ty_reg   <= p1s * ay;
                // polynomial and tangential shifts
                c4_reg   <= c3_reg;
                r2_4_reg <= r2_3_reg;
                poly_reg <= 34'($signed(kp_reg[44:12])) + (34'(k1s) <<< 4);
                ddx_reg  <= 35'($signed(sxy1_reg[44:11])) + 35'($signed(tx_reg[45:12]));
                ddy_reg  <= 35'($signed(ty_reg[45:12])) + 35'($signed(sxy2_reg[44:11]));
                // denominator product and corrected numerators
                c5_reg <= c4_reg;
                pm_reg <= poly_reg * r2_4_reg;
                nx_reg <= 36'($signed(c4_reg.x0)) - 36'(ddx_reg);
                ny_reg <= 36'($signed(c4_reg.y0)) - 36'(ddy_reg);
            end
        end

        assign denom      = 48'($signed(pm_reg[62:16])) + 48'(ONE_Q16);
        assign fault_next = c5_reg.fault | denom[47] | (denom == '0);
        assign nx_mag     = nx_reg[35] ? 36'(-nx_reg) : 36'(nx_reg);
        assign ny_mag     = ny_reg[35] ? 36'(-ny_reg) : 36'(ny_reg);

        ilu_div #(.NW(52), .DW(47), .SW(40)) u_div_x (
            .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v5_reg),
            .num_mag({nx_mag, 16'b0}), .num_neg(nx_reg[35]), .den(denom[46:0]),
            .side_in({fault_next, c5_reg.px, c5_reg.x0}),
            .vld_out(dxv), .quo(qx), .side_out(sx_out)
        );

        ilu_div #(.NW(52), .DW(47), .SW(39)) u_div_y (
            .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v5_reg),
            .num_mag({ny_mag, 16'b0}), .num_neg(ny_reg[35]), .den(denom[46:0]),
            .side_in({c5_reg.py, c5_reg.y0}),
            .vld_out(dyv), .quo(qy), .side_out(sy_out)
        );

        always_comb
        begin
            it_c[g+1].fault = sx_out[39];
            it_c[g+1].px    = sx_out[38:23];
            it_c[g+1].x0    = $signed(sx_out[22:0]);
            it_c[g+1].py    = sy_out[38:23];
            it_c[g+1].y0    = $signed(sy_out[22:0]);
            it_c[g+1].x     = qx;
            it_c[g+1].y     = qy;
            it_v[g+1]       = dxv & dyv;
        end
    end

    // rescale to pixels
    logic               f1_vld_reg;
    logic signed [39:0] f1_px_reg, f1_py_reg;
    logic [15:0]        f1_inx_reg, f1_iny_reg;
    logic               f1_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= it_v[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_px_reg    <= $signed(it_c[ITERATIONS].x) * $signed({1'b0, fx_eff});
            f1_py_reg    <= $signed(it_c[ITERATIONS].y) * $signed({1'b0, fy_eff});
            f1_inx_reg   <= it_c[ITERATIONS].px;
            f1_iny_reg   <= it_c[ITERATIONS].py;
            f1_fault_reg <= it_c[ITERATIONS].fault;
        end
    end

    logic [24:0] sx, sy;
    logic        sat_x, sat_y;
    logic [15:0] cor_x, cor_y;
    out_beat_t   res;

    assign sx = 25'($signed(f1_px_reg[39:16])) + 25'({1'b0, center_x_reg});
    assign sy = 25'($signed(f1_py_reg[39:16])) + 25'({1'b0, center_y_reg});
    assign sat_x = sx[24] | (sx[23:16] != '0);
    assign sat_y = sy[24] | (sy[23:16] != '0);
    assign cor_x = sx[24] ? 16'd0 : (sat_x ? 16'hFFFF : sx[15:0]);
    assign cor_y = sy[24] ? 16'd0 : (sat_y ? 16'hFFFF : sy[15:0]);

    always_comb
    begin
        if (f1_fault_reg)
        begin
            res.corrected_x = f1_inx_reg;
            res.corrected_y = f1_iny_reg;
            res.status      = STATUS_DENOM;
        end
        else
        begin
            res.corrected_x = cor_x;
            res.corrected_y = cor_y;
            res.status      = (sat_x | sat_y) ? STATUS_SAT : STATUS_OK;
        end
    end

    // output register and skid stage
    logic      out_vld_reg, skid_vld_reg, produce;
    out_beat_t out_data_reg, skid_data_reg;

    assign en      = !skid_vld_reg;
    assign produce = f1_vld_reg & en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_ready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= produce;
            end
        end
        else if (produce)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_ready)
        begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : res;
        end
        else if (produce)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // skid beat only exists behind a held output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid beat without output beat");

    // full skid stage freezes the pipe for that cycle
    a_skid_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> !in_ready && !produce)
        else $error("pipe advanced with skid full");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_data_reg.status == STATUS_OK ||
                         out_data_reg.status == STATUS_SAT ||
                         out_data_reg.status == STATUS_DENOM))
        else $error("bad status code");

endmodule

[tb/sv/ilu_checker.sv]
`timescale 1ns / 1ps
// scoreboard for the iterative lens undistortion block: predicts each output beat
// from the camera registers and compares it with what the block delivers
// depends on ilu_pkg
module ilu_checker #(
    parameter int ITERATIONS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ilu_pkg::in_beat_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ilu_pkg::out_beat_t out_data,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 beats_checked
);
    import ilu_pkg::*;

    logic [15:0] cam_fx, cam_fy, cam_cx, cam_cy;
    logic signed [15:0] cam_k1, cam_k2, cam_p1, cam_p2;
    out_beat_t corrected_q[$];

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint clamp_norm(longint v);
        if (v > 64'sd2097152)
            return 64'sd2097152;
        if (v < -64'sd2097152)
            return -64'sd2097152;
        return v;
    endfunction

    function automatic logic [15:0] rescale(longint n, longint f, longint c, ref logic sat);
        longint p;
        p = floor_shift(n * f, 16) + c;
        if (p < 0)
        begin
            sat = 1'b1;
            return 16'd0;
        end
        if (p > 65535)
        begin
            sat = 1'b1;
            return 16'hffff;
        end
        return p[15:0];
    endfunction

    function automatic out_beat_t undistort(in_beat_t b);
        out_beat_t r;
        longint fx, fy, cx, cy, k1, k2, p1, p2, x0, y0, x, y;
        longint xx, yy, xy, r2, poly, den, ddx, ddy;
        logic sat;
        fx = (cam_fx == 0) ? 1 : cam_fx;
        fy = (cam_fy == 0) ? 1 : cam_fy;
        cx = cam_cx;
        cy = cam_cy;
        k1 = cam_k1;
        k2 = cam_k2;
        p1 = cam_p1;
        p2 = cam_p2;
        sat = 1'b0;
        x0 = clamp_norm(((longint'(b.pixel_x) - cx) * 65536) / fx);
        y0 = clamp_norm(((longint'(b.pixel_y) - cy) * 65536) / fy);
        x = x0;
        y = y0;
        for (int i = 0; i < ITERATIONS; i++)
        begin
            xx = floor_shift(x * x, 16);
            yy = floor_shift(y * y, 16);
            xy = floor_shift(x * y, 16);
            r2 = floor_shift(x * x + y * y, 16);
            poly = floor_shift(k2 * r2, 12) + k1 * 16;
            den = 65536 + floor_shift(poly * r2, 16);
            if (den <= 0)
            begin
                r.corrected_x = b.pixel_x;
                r.corrected_y = b.pixel_y;
                r.status = STATUS_DENOM;
                return r;
            end
            ddx = floor_shift(2 * p1 * xy, 12) + floor_shift(p2 * (r2 + 2 * xx), 12);
            ddy = floor_shift(p1 * (r2 + 2 * yy), 12) + floor_shift(2 * p2 * xy, 12);
            x = clamp_norm(((x0 - ddx) * 65536) / den);
            y = clamp_norm(((y0 - ddy) * 65536) / den);
        end
        r.corrected_x = rescale(x, fx, cx, sat);
        r.corrected_y = rescale(y, fy, cy, sat);
        r.status = sat ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    assign pending_count = corrected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t e;
        if (!rst_n)
        begin
            cam_fx <= 16'd8000;
            cam_fy <= 16'd8000;
            cam_cx <= 16'd5120;
            cam_cy <= 16'd3840;
            cam_k1 <= '0;
            cam_k2 <= '0;
            cam_p1 <= '0;
            cam_p2 <= '0;
            corrected_q.delete();
            fail_count = 0;
            beats_checked = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                corrected_q.push_back(undistort(in_data));
            if (out_valid && out_ready)
            begin
                beats_checked++;
                if (corrected_q.size() == 0)
                    report_mismatch("unexpected beat", 1, 0);
                else
                begin
                    e = corrected_q.pop_front();
                    if (out_data.corrected_x !== e.corrected_x)
                        report_mismatch("corrected_x", out_data.corrected_x, e.corrected_x);
                    if (out_data.corrected_y !== e.corrected_y)
                        report_mismatch("corrected_y", out_data.corrected_y, e.corrected_y);
                    if (out_data.status !== e.status)
                        report_mismatch("status", out_data.status, e.status);
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FOCAL_X:       cam_fx <= cfg_data;
                    REG_FOCAL_Y:       cam_fy <= cfg_data;
                    REG_CENTER_X:      cam_cx <= cfg_data;
                    REG_CENTER_Y:      cam_cy <= cfg_data;
                    REG_RADIAL_K1:     cam_k1 <= cfg_data;
                    REG_RADIAL_K2:     cam_k2 <= cfg_data;
                    REG_TANGENTIAL_P1: cam_p1 <= cfg_data;
                    REG_TANGENTIAL_P2: cam_p2 <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/sv/tb_iterative_lens_undistort_top.sv]
`timescale 1ns / 1ps
// top of the lens undistortion testbench: clock, reset, camera setups, pixel stimulus
// depends on ilu_pkg, iterative_lens_undistort_top and ilu_checker
module tb_iterative_lens_undistort_top;
    import ilu_pkg::*;

    localparam int LATENCY = 29 + 31 * 5;
    localparam longint CYCLE_LIMIT = 1500000;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    in_beat_t in_data;
    out_beat_t out_data;
    logic cfg_write;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    int fail_count, pending_count, beats_checked;
    int send_idle, recv_idle, hold_cycles;
    longint cycle_count;
    int sent;

    iterative_lens_undistort_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ilu_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .beats_checked(beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // valid stays up between back to back beats and drops only for idle cycles
    task automatic send_pixel(logic [15:0] px, logic [15:0] py);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        in_data <= '{pixel_x: px, pixel_y: py};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_camera(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
                               logic [15:0] cy, logic [15:0] k1, logic [15:0] k2,
                               logic [15:0] p1, logic [15:0] p2);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIAL_K1, k1);
        write_reg(REG_RADIAL_K2, k2);
        write_reg(REG_TANGENTIAL_P1, p1);
        write_reg(REG_TANGENTIAL_P2, p2);
        cfg_write <= 1'b0;
    endtask

    // mostly pixels near the image, some anywhere in the coordinate range
    task automatic random_pixels(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                send_pixel(16'($urandom_range(65535)), 16'($urandom_range(65535)));
            else
                send_pixel(16'($urandom_range(12000, 0)), 16'($urandom_range(9000, 0)));
        end
    endtask

    task automatic random_camera();
        load_camera(16'($urandom_range(65535, 1000)), 16'($urandom_range(65535, 1000)),
                    16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(3000) - 1500), 16'($urandom_range(3000) - 1500),
                    16'($urandom_range(400) - 200), 16'($urandom_range(400) - 200));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle = 14;
        recv_idle = 66;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset camera, corners, center, extremes
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hffff, 16'hffff);
        send_pixel(16'd5120, 16'd3840);
        send_pixel(16'hffff, 16'd0);
        send_pixel(16'haaaa, 16'h5555);
        send_pixel(16'h5555, 16'haaaa);
        drain();
        // strong barrel distortion, zero focal, tangential extremes
        load_camera(16'd0, 16'd0, 16'hffff, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hffff, 16'hffff);
        send_pixel(16'hffff, 16'd1);
        drain();
        // negative k drives the denominator non-positive
        load_camera(16'd4000, 16'd4000, 16'd5120, 16'd3840, 16'h8000, 16'h8000, 16'd0, 16'd0);
        send_pixel(16'd5120, 16'd3840);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'd9000, 16'd7000);
        send_pixel(16'd5200, 16'd3900);
        drain();
        load_camera(16'hffff, 16'hffff, 16'd0, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        send_pixel(16'd0, 16'hffff);
        send_pixel(16'hffff, 16'd0);
        send_pixel(16'd100, 16'd100);
        drain();

        // random phases, sender idle low and receiver high
        for (int ph = 0; ph < 3; ph++)
        begin
            random_camera();
            if (ph == 1)
            begin
                random_pixels(10);
                hold_cycles <= 600;
                random_pixels(240);
            end
            else
                random_pixels(150);
            drain();
        end
        send_idle = 66;
        recv_idle = 14;
        for (int ph = 0; ph < 3; ph++)
        begin
            random_camera();
            random_pixels(150);
            drain();
        end
        send_idle = 0;
        recv_idle = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 0)
                load_camera(16'd8000, 16'd8000, 16'd5120, 16'd3840, 16'd0, 16'd0, 16'd0, 16'd0);
            else
                random_camera();
            if (ph == 2)
            begin
                random_pixels(10);
                hold_cycles <= 400;
                random_pixels(240);
            end
            else
                random_pixels(100);
            drain();
        end

        $display("sent %0d pixels over a dozen camera setups, %0d results checked",
                 sent, beats_checked);
        $display("setups covered reset values, register extremes, bad denominators and full pipe stalls");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
